FILE: rtl/pcms_pkg.sv
// Shared types and constants of the pair count-min sketch.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none
package pcms_pkg;
	localparam int KEY_W  = 31;
	localparam int HASH_W = 32;
	localparam int BC_W   = 13;
	localparam logic [BC_W-1:0] BC_RESET = 13'd4096;
	localparam logic [KEY_W-1:0] PRIME = 31'h7FFFFFFF;

	typedef enum logic [1:0] {
		KIND_ADD  = 2'd0,
		KIND_EST  = 2'd1,
		KIND_SEED = 2'd2,
		KIND_NOP  = 2'd3
	} kind_t;

	// one classified word as it travels from front to back
	typedef struct packed {
		kind_t             kind;
		logic [KEY_W-1:0]  larger;
		logic [KEY_W-1:0]  smaller;
		logic [1:0]        seed_row;
		logic [KEY_W-1:0]  seed_ml;
		logic [KEY_W-1:0]  seed_ms;
		logic [KEY_W-1:0]  seed_off;
	} item_t;
endpackage
`default_nettype wire

FILE: rtl/pcms_front.sv
// Front end: accepts input words, orders the key pair, drops unused kinds.
// Depends on pcms_pkg.
`default_nettype none
module pcms_front (
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [159:0]  s_tdata,
	input  wire logic [1:0]    s_tuser,
	input  wire logic          clearing,
	input  wire logic          q_full,
	output logic               q_push,
	output pcms_pkg::item_t    q_item
);
	import pcms_pkg::*;

	logic [KEY_W-1:0] k1, k2;

	assign k1 = s_tdata[30:0];
	assign k2 = s_tdata[61:31];

	// no words while the counters are being swept
	assign s_tready = !q_full && !clearing;

	// classify; an unused kind is taken and dropped
	always_comb begin
		q_item.kind     = kind_t'(s_tuser);
		q_item.larger   = (k1 < k2) ? k2 : k1;
		q_item.smaller  = (k1 < k2) ? k1 : k2;
		q_item.seed_row = s_tdata[63:62];
		q_item.seed_ml  = s_tdata[94:64];
		q_item.seed_ms  = s_tdata[125:95];
		q_item.seed_off = s_tdata[156:126];
		q_push = s_tvalid && s_tready && (kind_t'(s_tuser) != KIND_NOP);
	end
endmodule
`default_nettype wire

FILE: rtl/pcms_fifo.sv
// Two-entry queue of classified words between front and back.
// Depends on pcms_pkg.
`default_nettype none
module pcms_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire pcms_pkg::item_t  push_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  not_empty,
	output pcms_pkg::item_t       head
);
	import pcms_pkg::*;

	item_t      mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end
endmodule
`default_nettype wire

FILE: rtl/pcms_back.sv
// Back end: per-row hash sequencer, counter memory and result register.
// Depends on pcms_pkg.
`default_nettype none
module pcms_back #(
	parameter int ROWS          = 4,
	parameter int BUCKET_DEPTH  = 4096,
	parameter int COUNTER_WIDTH = 32,
	parameter int DW            = $clog2(BUCKET_DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [DW-1:0]    divisor,
	input  wire logic             q_valid,
	input  wire pcms_pkg::item_t  q_item,
	output logic                  q_pop,
	output logic                  clearing,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [31:0]           m_tdata
);
	import pcms_pkg::*;

	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int DEPTH = ROWS * BUCKET_DEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = COUNTER_WIDTH;
	localparam logic [CW-1:0] CMAX = {CW{1'b1}};

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_MUL1, ST_MUL2, ST_PRIME,
		ST_DIV, ST_RD, ST_EVAL, ST_OUT
	} state_t;

	state_t            state_q;
	item_t             cur_q;
	logic [RW-1:0]     row_q;
	logic [AW-1:0]     base_q, addr_q, clr_q;
	logic [HASH_W-1:0] prod_q, h_q;
	logic [DW-1:0]     rem_q;
	logic [4:0]        cnt_q;
	logic [CW-1:0]     min_q, rd_q;

	logic [KEY_W-1:0] ml_tab [ROWS];
	logic [KEY_W-1:0] ms_tab [ROWS];
	logic [KEY_W-1:0] off_tab[ROWS];
	logic [CW-1:0]    cnt_mem[DEPTH];

	logic              seed_ok;
	logic [RW-1:0]     seed_idx;
	logic [2*KEY_W-1:0] mul_a, mul_b;
	logic [HASH_W-1:0] fold, fold_m;
	logic [DW:0]       trial;
	logic              mem_we;
	logic [AW-1:0]     mem_wa;
	logic [CW-1:0]     mem_wd, rd_inc;

	assign clearing = (state_q == ST_CLEAR);
	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign seed_ok  = (32'(q_item.seed_row) < ROWS);
	assign seed_idx = RW'(q_item.seed_row);

	// hash arithmetic
	assign mul_a  = ml_tab[row_q] * cur_q.larger;
	assign mul_b  = ms_tab[row_q] * cur_q.smaller;
	assign fold   = {1'b0, h_q[30:0]} + HASH_W'(h_q[31]);
	assign fold_m = (fold >= HASH_W'(PRIME)) ? fold - HASH_W'(PRIME) : fold;
	assign trial  = {rem_q, h_q[HASH_W-1]};
	assign rd_inc = (rd_q == CMAX) ? rd_q : rd_q + CW'(1);

	// counter memory write port: sweep or increment
	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_q;
		mem_wd = rd_inc;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else if (state_q == ST_EVAL && cur_q.kind == KIND_ADD) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) cnt_mem[mem_wa] <= mem_wd;
		if (state_q == ST_RD) rd_q <= cnt_mem[addr_q];
	end

	// seed tables
	always_ff @(posedge clk) begin
		if (q_pop && q_item.kind == KIND_SEED && seed_ok) begin
			ml_tab[seed_idx]  <= q_item.seed_ml;
			ms_tab[seed_idx]  <= q_item.seed_ms;
			off_tab[seed_idx] <= q_item.seed_off;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_valid) begin
						cur_q  <= q_item;
						row_q  <= '0;
						base_q <= '0;
						min_q  <= CMAX;
						if (q_item.kind != KIND_SEED) state_q <= ST_MUL1;
					end
				end
				ST_MUL1: begin
					prod_q  <= mul_a[HASH_W-1:0];
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					h_q     <= prod_q + mul_b[HASH_W-1:0];
					state_q <= ST_PRIME;
				end
				ST_PRIME: begin
					h_q     <= fold_m + HASH_W'(off_tab[row_q]);
					rem_q   <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				// one quotient bit per cycle, remainder only
				ST_DIV: begin
					h_q   <= {h_q[HASH_W-2:0], 1'b0};
					rem_q <= (trial >= {1'b0, divisor}) ? DW'(trial - {1'b0, divisor})
					                                    : DW'(trial);
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (rd_q < min_q) min_q <= rd_q;
					if (32'(row_q) == ROWS - 1) begin
						state_q <= (cur_q.kind == KIND_EST) ? ST_OUT : ST_IDLE;
					end else begin
						row_q   <= row_q + RW'(1);
						base_q  <= base_q + AW'(BUCKET_DEPTH);
						state_q <= ST_MUL1;
					end
				end
				ST_OUT: begin
					if (!m_tvalid || m_tready) begin
						m_tdata  <= 32'(min_q);
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// output register: load a finished estimate, or clear once taken
			if (state_q == ST_OUT && (!m_tvalid || m_tready)) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			// address latches after the last divide step
			if (state_q == ST_DIV && cnt_q == 5'd31) begin
				addr_q <= base_q + AW'((trial >= {1'b0, divisor})
				                       ? DW'(trial - {1'b0, divisor}) : DW'(trial));
			end
		end
	end
endmodule
`default_nettype wire

FILE: rtl/pair_count_min_sketch.sv
// Top level of the pair count-min sketch: config register, front, queue, back.
// Depends on pcms_pkg, pcms_front, pcms_fifo, pcms_back.
//
// Usage:
//   s_* : input words. s_tuser = kind (0 add, 1 estimate, 2 seed write).
//         s_tdata packs key_first, key_second, seed_row, seed_mult_larger,
//         seed_mult_smaller, seed_offset from bit 0 up.
//   m_* : one word per estimate item, m_tdata = estimate.
//   cfg_we/cfg_wdata : write bucket_count (reset 4096); write only while idle.
// Each row takes two multiplies, a prime fold, a 32-step bit-serial remainder
// by the bucket count, one memory read and, for an add, a write; an add or
// estimate walks all ROWS rows before the next pop; a seed write is done in
// idle. The single-port counter memory and bit-serial remainder set the rate.
// A two-word queue lets the front take words while the back works.
// After reset all counters are swept to zero with s_tready low. When m_tready
// is low the finished estimate waits in the output register and the back
// stalls at its next estimate only.
`default_nettype none
module pair_count_min_sketch #(
	parameter int ROWS          = 4,
	parameter int BUCKET_DEPTH  = 4096,
	parameter int COUNTER_WIDTH = 32
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// key_first, key_second, seed_row, seed_mult_larger, seed_mult_smaller, seed_offset
	input  wire logic [159:0] s_tdata,
	// kind
	input  wire logic [1:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// estimate
	output logic [31:0]       m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [12:0]  cfg_wdata
);
	import pcms_pkg::*;

	localparam int DW = $clog2(BUCKET_DEPTH + 1);

	logic [BC_W-1:0] bc_q;
	logic [DW-1:0]   divisor;
	logic            clearing, q_full, q_push, q_pop, q_valid;
	item_t           q_in, q_head;

	// bucket count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bc_q <= BC_RESET;
		else if (cfg_we) bc_q <= cfg_wdata;
	end

	// zero means one, above depth means depth
	always_comb begin
		if (bc_q == '0) divisor = DW'(1);
		else if (32'(bc_q) > BUCKET_DEPTH) divisor = DW'(BUCKET_DEPTH);
		else divisor = DW'(bc_q);
	end

	pcms_front u_front (
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.clearing, .q_full, .q_push, .q_item(q_in)
	);

	pcms_fifo u_fifo (
		.clk, .arst_n, .push(q_push), .push_item(q_in), .full(q_full),
		.pop(q_pop), .not_empty(q_valid), .head(q_head)
	);

	pcms_back #(
		.ROWS(ROWS), .BUCKET_DEPTH(BUCKET_DEPTH),
		.COUNTER_WIDTH(COUNTER_WIDTH), .DW(DW)
	) u_back (
		.clk, .arst_n, .divisor, .q_valid, .q_item(q_head), .q_pop,
		.clearing, .m_tvalid, .m_tready, .m_tdata
	);
endmodule
`default_nettype wire

FILE: rtl/pcms_checker.sv
// Port-level checks of the pair count-min sketch, bound to the top level.
// Depends on pair_count_min_sketch ports only.
`default_nettype none
module pcms_checker #(
	parameter int COUNTER_WIDTH = 32
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);
	// stalled estimate holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("estimate changed under stall");

	// estimate fits a counter
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata >> COUNTER_WIDTH) == 32'd0))
		else $error("estimate wider than a counter");

	// counter sweep blocks input right after reset
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !s_tready)
		else $error("input taken during counter sweep");
endmodule

bind pair_count_min_sketch pcms_checker #(.COUNTER_WIDTH(COUNTER_WIDTH)) u_chk (.*);
`default_nettype wire
